[hdl/priority_weighted_three_queue_arbiter_defines.svh]
// Assertion macros shared by the arbiter's checker.
`ifndef PRIORITY_WEIGHTED_THREE_QUEUE_ARBITER_DEFINES_SVH
`define PRIORITY_WEIGHTED_THREE_QUEUE_ARBITER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define PWTQA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pwtqa: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define PWTQA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pwtqa: next-cycle check failed");

// Next-cycle implication that also holds across reset.
`define PWTQA_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("pwtqa: reset check failed");

`endif

[hdl/pwtqa_pkg.sv]
// Types, codes and constants of the three-queue arbiter.
package pwtqa_pkg;

    localparam int ID_W            = 16;
    localparam int CLS_W           = 2;
    localparam int ST_W            = 2;
    localparam int LIMIT_W         = 4;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 4;
    localparam int NUM_QUEUES      = 3;
    localparam int DEF_QUEUE_DEPTH = 16;

    // Request function codes
    localparam logic FUNC_ENQUEUE = 1'b0;
    localparam logic FUNC_GRANT   = 1'b1;

    // Queue classes
    localparam logic [CLS_W-1:0] CLS_EMERG  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_ARRIVE = 2'd1;
    localparam logic [CLS_W-1:0] CLS_DEPART = 2'd2;

    // Response status codes
    localparam logic [ST_W-1:0] ST_GRANTED  = 2'd0;
    localparam logic [ST_W-1:0] ST_IDLE     = 2'd1;
    localparam logic [ST_W-1:0] ST_ENQUEUED = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPART_LIMIT = 1'd1;

    // Burst limits after reset
    localparam logic [LIMIT_W-1:0] ARRIVE_LIMIT_RST = 4'd3;
    localparam logic [LIMIT_W-1:0] DEPART_LIMIT_RST = 4'd2;

    typedef struct packed {
        logic             func;
        logic [ID_W-1:0]  req_id;
        logic [CLS_W-1:0] req_class;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [ID_W-1:0]  grant_id;
        logic [CLS_W-1:0] grant_class;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic load_now;
        logic load_pop;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic needs_pop;
    } t_dp_sts;

endpackage

[hdl/pwtqa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pwtqa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[hdl/pwtqa_ctrl.sv]
// Controller: request handshake, pop wait state and result valid.
module pwtqa_ctrl
    import pwtqa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_POP  = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic accept;

    // Take a request only when the result register is free or draining now
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.accept   = accept;
        o_cmd.load_now = accept && !i_sts.needs_pop;
        o_cmd.load_pop = (r_state == S_POP);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_sts.needs_pop) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_now || o_cmd.load_pop) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

[hdl/pwtqa_dp.sv]
// Datapath: queue storage and pointers, turn logic, limits, result register.
module pwtqa_dp
    import pwtqa_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_req                  i_req,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output t_rsp                  o_rsp
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    logic [PTR_W-1:0]   r_head  [NUM_QUEUES];
    logic [PTR_W-1:0]   r_tail  [NUM_QUEUES];
    logic [CNT_W-1:0]   r_count [NUM_QUEUES];
    logic               r_arrive_turn;
    logic [LIMIT_W-1:0] r_arrive_run, r_depart_run;
    logic [LIMIT_W-1:0] n_arrive_run, n_depart_run;
    logic [LIMIT_W-1:0] r_arrive_limit, r_depart_limit;
    logic [CLS_W-1:0]   r_pop_cls;
    t_rsp               r_rsp;

    logic [ID_W-1:0]       ram_rdata [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] enq_hit, pop_hit;
    logic                  is_grant, e_ne, a_ne, d_ne, sel_arrive, sel_depart, any_ne;
    logic [CLS_W-1:0]      pop_cls;
    logic [ID_W-1:0]       pop_id;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
    endfunction

    // Grant decision: emergency first, then arriving/departing by turn
    always_comb begin
        is_grant   = (i_req.func == FUNC_GRANT);
        e_ne       = (r_count[CLS_EMERG] != '0);
        a_ne       = (r_count[CLS_ARRIVE] != '0);
        d_ne       = (r_count[CLS_DEPART] != '0);
        any_ne     = e_ne || a_ne || d_ne;
        sel_arrive = !e_ne && a_ne && (r_arrive_turn || !d_ne);
        sel_depart = !e_ne && !sel_arrive && d_ne && (!r_arrive_turn || !a_ne);
        if (e_ne) begin
            pop_cls = CLS_EMERG;
        end else if (sel_arrive) begin
            pop_cls = CLS_ARRIVE;
        end else begin
            pop_cls = CLS_DEPART;
        end
        o_sts.needs_pop = is_grant && any_ne;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            enq_hit[q] = !is_grant && (i_req.req_class == CLS_W'(q))
                         && (r_count[q] != FULL_CNT);
            pop_hit[q] = is_grant && any_ne && (pop_cls == CLS_W'(q));
        end
    end

    // One RAM per queue
    for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_queue
        pwtqa_ram #(
            .WIDTH (ID_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (i_cmd.accept && enq_hit[g]),
            .i_waddr (r_tail[g]),
            .i_wdata (i_req.req_id),
            .i_re    (i_cmd.accept && pop_hit[g]),
            .i_raddr (r_head[g]),
            .o_rdata (ram_rdata[g])
        );
    end

    // Pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                r_head[q]  <= '0;
                r_tail[q]  <= '0;
                r_count[q] <= '0;
            end
        end else if (i_cmd.accept) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                if (enq_hit[q]) begin
                    r_tail[q]  <= ptr_inc(r_tail[q]);
                    r_count[q] <= r_count[q] + CNT_W'(1);
                end
                if (pop_hit[q]) begin
                    r_head[q]  <= ptr_inc(r_head[q]);
                    r_count[q] <= r_count[q] - CNT_W'(1);
                end
            end
        end
    end

    // Burst run counters
    always_comb begin
        n_arrive_run = r_arrive_run + LIMIT_W'(1);
        n_depart_run = r_depart_run + LIMIT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrive_turn <= 1'b1;
            r_arrive_run  <= '0;
            r_depart_run  <= '0;
        end else if (i_cmd.accept && is_grant) begin
            if (sel_arrive) begin
                if (n_arrive_run >= r_arrive_limit) begin
                    r_arrive_turn <= 1'b0;
                    r_arrive_run  <= '0;
                end else begin
                    r_arrive_run  <= n_arrive_run;
                end
            end else if (sel_depart) begin
                if (n_depart_run >= r_depart_limit) begin
                    r_arrive_turn <= 1'b1;
                    r_depart_run  <= '0;
                end else begin
                    r_depart_run  <= n_depart_run;
                end
            end
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrive_limit <= ARRIVE_LIMIT_RST;
            r_depart_limit <= DEPART_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ARRIVE_LIMIT: r_arrive_limit <= i_cfg_data;
                REG_DEPART_LIMIT: r_depart_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Read data of the queue that was popped
    always_comb begin
        case (r_pop_cls)
            CLS_EMERG:  pop_id = ram_rdata[CLS_EMERG];
            CLS_ARRIVE: pop_id = ram_rdata[CLS_ARRIVE];
            default:    pop_id = ram_rdata[CLS_DEPART];
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pop_cls <= pop_cls;
        end
        if (i_cmd.load_now) begin
            r_rsp.grant_id    <= '0;
            r_rsp.grant_class <= '0;
            if (is_grant) begin
                r_rsp.status <= ST_IDLE;
            end else if (|enq_hit) begin
                r_rsp.status <= ST_ENQUEUED;
            end else begin
                r_rsp.status <= ST_FULL;
            end
        end else if (i_cmd.load_pop) begin
            r_rsp.status      <= ST_GRANTED;
            r_rsp.grant_id    <= pop_id;
            r_rsp.grant_class <= r_pop_cls;
        end
    end

    assign o_rsp = r_rsp;
endmodule

[hdl/priority_weighted_three_queue_arbiter.sv]
// Three-queue arbiter top level: strict emergency priority, weighted turns otherwise.
// An enqueue request, or a grant request that finds all queues empty, has its
// result registered at the edge that accepts it. A grant that pops a queue
// reads the queue RAM through its registered read port, then the pop wait state
// loads the result; no request is accepted in that state. A new request is taken
// while the previous result is being handed off in the same cycle. Queues are
// QUEUE_DEPTH entries each; the burst limits are written through the
// configuration port (index 0 arriving, index 1 departing) and reset to 3 and 2.
module priority_weighted_three_queue_arbiter
    import pwtqa_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_req                  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_rsp                  o_out_data
);
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // Sequencing
    pwtqa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    // Queues and arbitration state
    pwtqa_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (i_in_data),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_rsp      (o_out_data)
    );
endmodule

[hdl/pwtqa_chk.sv]
// Port-level checker for the three-queue arbiter, bound to the top level.
`include "priority_weighted_three_queue_arbiter_defines.svh"

module pwtqa_chk
    import pwtqa_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_req                  i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_rsp                  o_out_data
);
    // Class 3 names no queue
    localparam logic [CLS_W-1:0] CLS_UNUSED = 2'd3;

    logic in_acc;
    logic enq_acc;
    logic bad_cls_acc;
    logic out_stall;
    logic rsp_no_grant;
    logic rsp_fields_zero;
    logic rsp_enq_answer;
    logic rsp_full;

    assign in_acc          = i_in_valid && o_in_ready;
    assign enq_acc         = in_acc && (i_in_data.func == FUNC_ENQUEUE);
    assign bad_cls_acc     = enq_acc && (i_in_data.req_class == CLS_UNUSED);
    assign out_stall       = o_out_valid && !i_out_ready;
    assign rsp_no_grant    = o_out_valid && (o_out_data.status != ST_GRANTED);
    assign rsp_fields_zero = (o_out_data.grant_id == '0) && (o_out_data.grant_class == '0);
    assign rsp_enq_answer  = o_out_valid && ((o_out_data.status == ST_ENQUEUED)
                                             || (o_out_data.status == ST_FULL));
    assign rsp_full        = o_out_valid && (o_out_data.status == ST_FULL);

    // Reset leaves no result pending
    `PWTQA_ASSERT_NEXT_ALWAYS(a_reset_clears, !i_rst_n, !o_out_valid)

    // A stalled result holds
    `PWTQA_ASSERT_NEXT(a_out_hold, out_stall, o_out_valid && $stable(o_out_data))

    // Non-grant results carry no identifier or class
    `PWTQA_ASSERT_SAME(a_zero_fields, rsp_no_grant, rsp_fields_zero)

    // Enqueue answers in the next cycle with enqueued or full
    `PWTQA_ASSERT_NEXT(a_enq_answer, enq_acc, rsp_enq_answer)

    // Unused class is always dropped
    `PWTQA_ASSERT_NEXT(a_bad_class, bad_cls_acc, rsp_full)
endmodule

bind priority_weighted_three_queue_arbiter pwtqa_chk u_pwtqa_chk (.*);

[bench/tb_top.sv]
// Self-checking testbench for the three-queue arbiter: directed table, then random phases.
`timescale 1ns / 1ps

module tb_top;
    import pwtqa_pkg::*;

    localparam int DEPTH          = DEF_QUEUE_DEPTH;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT    = 40;

    // Class 3 is not a queue; zero class is reported when nothing is granted
    localparam logic [CLS_W-1:0] CLS_UNUSED = 2'd3;
    localparam logic [CLS_W-1:0] CLS_NONE   = 2'd0;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;
    typedef enum int {RX_OPEN, RX_COIN, RX_HOLD} t_rx_mode;

    typedef struct {
        t_row_kind          kind;
        logic               func;
        logic [ID_W-1:0]    req_id;
        logic [CLS_W-1:0]   req_class;
        int                 reps;
        bit                 typed;
        logic [ST_W-1:0]    status;
        logic [ID_W-1:0]    grant_id;
        logic [CLS_W-1:0]   grant_class;
        logic [LIMIT_W-1:0] arrive_lim;
        logic [LIMIT_W-1:0] depart_lim;
    } t_row;

    // Directed rows; repeated requests step req_id by one. Typed rows carry their answer.
    t_row dir_rows [0:12] = '{
        '{ROW_REQ, FUNC_GRANT,   16'h0000, CLS_EMERG,  1,  1'b1, ST_IDLE,     16'h0000, CLS_NONE,
          4'd0, 4'd0},
        '{ROW_REQ, FUNC_ENQUEUE, 16'hFFFF, CLS_UNUSED, 1,  1'b1, ST_FULL,     16'h0000, CLS_NONE,
          4'd0, 4'd0},
        '{ROW_REQ, FUNC_ENQUEUE, 16'hFFFF, CLS_EMERG,  1,  1'b1, ST_ENQUEUED, 16'h0000, CLS_NONE,
          4'd0, 4'd0},
        '{ROW_REQ, FUNC_ENQUEUE, 16'h0000, CLS_ARRIVE, 1,  1'b1, ST_ENQUEUED, 16'h0000, CLS_NONE,
          4'd0, 4'd0},
        '{ROW_REQ, FUNC_ENQUEUE, 16'h8000, CLS_DEPART, 16, 1'b0, ST_IDLE,     16'h0000, CLS_NONE,
          4'd0, 4'd0},
        '{ROW_REQ, FUNC_ENQUEUE, 16'h7FFF, CLS_DEPART, 1,  1'b1, ST_FULL,     16'h0000, CLS_NONE,
          4'd0, 4'd0},
        '{ROW_REQ, FUNC_GRANT,   16'hFFFF, CLS_UNUSED, 1,  1'b1, ST_GRANTED,  16'hFFFF, CLS_EMERG,
          4'd0, 4'd0},
        '{ROW_REQ, FUNC_GRANT,   16'h0000, CLS_ARRIVE, 1,  1'b0, ST_IDLE,     16'h0000, CLS_NONE,
          4'd0, 4'd0},
        '{ROW_REQ, FUNC_GRANT,   16'h0000, CLS_DEPART, 2,  1'b0, ST_IDLE,     16'h0000, CLS_NONE,
          4'd0, 4'd0},
        '{ROW_CFG, FUNC_GRANT,   16'h0000, CLS_NONE,   0,  1'b0, ST_IDLE,     16'h0000, CLS_NONE,
          4'd0, 4'd0},
        '{ROW_REQ, FUNC_ENQUEUE, 16'hAAAA, CLS_ARRIVE, 1,  1'b0, ST_IDLE,     16'h0000, CLS_NONE,
          4'd0, 4'd0},
        '{ROW_REQ, FUNC_GRANT,   16'h5555, CLS_EMERG,  3,  1'b0, ST_IDLE,     16'h0000, CLS_NONE,
          4'd0, 4'd0},
        '{ROW_CFG, FUNC_GRANT,   16'h0000, CLS_NONE,   0,  1'b0, ST_IDLE,     16'h0000, CLS_NONE,
          4'd15, 4'd15}
    };

    // DUT ports
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = REG_ARRIVE_LIMIT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_req                  i_in_data  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_rsp                  o_out_data;

    // Typed answer travels alongside the request it belongs to
    bit   req_typed     = 1'b0;
    t_rsp req_typed_rsp = '0;

    // Arbiter state as predicted
    logic [ID_W-1:0]    waiting_ids [NUM_QUEUES][$];
    logic               arrive_turn;
    logic [LIMIT_W-1:0] arrive_run;
    logic [LIMIT_W-1:0] depart_run;
    logic [LIMIT_W-1:0] arrive_limit;
    logic [LIMIT_W-1:0] depart_limit;

    t_rsp rsp_expected [$];

    int err_count   = 0;
    int n_sent      = 0;
    int n_granted [NUM_QUEUES] = '{0, 0, 0};
    int n_idle      = 0;
    int n_dropped   = 0;
    int n_settings  = 0;
    int burst_left  = 0;
    int quiet_count = 0;

    t_rx_mode rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;

    priority_weighted_three_queue_arbiter #(
        .QUEUE_DEPTH (DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Next arbiter answer for one request; updates the predicted state
    function automatic t_rsp arbitrate(t_req r);
        t_rsp rsp;
        int   na;
        int   nd;
        rsp = '0;
        if (r.func == FUNC_ENQUEUE) begin
            if (r.req_class == CLS_UNUSED || waiting_ids[r.req_class].size() >= DEPTH) begin
                rsp.status = ST_FULL;
            end else begin
                waiting_ids[r.req_class].push_back(r.req_id);
                rsp.status = ST_ENQUEUED;
            end
        end else begin
            na = waiting_ids[CLS_ARRIVE].size();
            nd = waiting_ids[CLS_DEPART].size();
            rsp.status = ST_GRANTED;
            if (waiting_ids[CLS_EMERG].size() > 0) begin
                rsp.grant_id    = waiting_ids[CLS_EMERG].pop_front();
                rsp.grant_class = CLS_EMERG;
            end else if (na > 0 && (arrive_turn || nd == 0)) begin
                rsp.grant_id    = waiting_ids[CLS_ARRIVE].pop_front();
                rsp.grant_class = CLS_ARRIVE;
                arrive_run = arrive_run + LIMIT_W'(1);
                if (arrive_run >= arrive_limit) begin
                    arrive_turn = 1'b0;
                    arrive_run  = '0;
                end
            end else if (nd > 0 && (!arrive_turn || na == 0)) begin
                rsp.grant_id    = waiting_ids[CLS_DEPART].pop_front();
                rsp.grant_class = CLS_DEPART;
                depart_run = depart_run + LIMIT_W'(1);
                if (depart_run >= depart_limit) begin
                    arrive_turn = 1'b1;
                    depart_run  = '0;
                end
            end else begin
                rsp.status = ST_IDLE;
            end
        end
        return rsp;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        err_count++;
        if (err_count <= PRINT_LIMIT)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // Scoreboard: responses against the oldest expectation, then new requests
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            foreach (waiting_ids[c]) waiting_ids[c].delete();
            arrive_turn  = 1'b1;
            arrive_run   = '0;
            depart_run   = '0;
            arrive_limit = ARRIVE_LIMIT_RST;
            depart_limit = DEPART_LIMIT_RST;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (rsp_expected.size() == 0) begin
                    report_mismatch("unexpected response", 32'(o_out_data), '0);
                end else begin
                    want = rsp_expected.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", 32'(o_out_data.status), 32'(want.status));
                    if (o_out_data.grant_id !== want.grant_id)
                        report_mismatch("grant_id", 32'(o_out_data.grant_id),
                                        32'(want.grant_id));
                    if (o_out_data.grant_class !== want.grant_class)
                        report_mismatch("grant_class", 32'(o_out_data.grant_class),
                                        32'(want.grant_class));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_ARRIVE_LIMIT)
                    arrive_limit = i_cfg_data;
                else if (i_cfg_idx == REG_DEPART_LIMIT)
                    depart_limit = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                want = arbitrate(i_in_data);
                if (req_typed)
                    want = req_typed_rsp;
                rsp_expected.push_back(want);
                case (want.status)
                    ST_GRANTED: n_granted[want.grant_class]++;
                    ST_IDLE:    n_idle++;
                    ST_FULL:    n_dropped++;
                    default: ;
                endcase
            end
        end
    end

    // Response side: open, coin-flip and long-hold stall modes
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN: i_out_ready <= 1'b1;
                RX_COIN: i_out_ready <= 1'($urandom_range(1));
                default: begin
                    if ($urandom_range(9) == 0) begin
                        hold_left   <= $urandom_range(1, 24);
                        i_out_ready <= 1'b0;
                    end else begin
                        i_out_ready <= 1'b1;
                    end
                end
            endcase
        end
        if (mode_left == 0) begin
            rx_mode   <= t_rx_mode'($urandom_range(2));
            mode_left <= $urandom_range(40, 250);
        end else begin
            mode_left <= mode_left - 1;
        end
    end

    // Watchdog: too long without any handshake ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("priority_weighted_three_queue_arbiter regression: fail");
            $finish;
        end
    end

    // One request; bursts of random length with random gaps in between
    task automatic send_req(t_req r, bit typed, t_rsp typed_rsp);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 30);
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_in_data     <= r;
        req_typed     <= typed;
        req_typed_rsp <= typed_rsp;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    // Stop sending and wait for every outstanding response
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (rsp_expected.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_limits(logic [LIMIT_W-1:0] arrive, logic [LIMIT_W-1:0] depart);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_ARRIVE_LIMIT;
        i_cfg_data <= arrive;
        @(posedge i_clk);
        i_cfg_idx  <= REG_DEPART_LIMIT;
        i_cfg_data <= depart;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        n_settings++;
    endtask

    // Extremes a good share of the time, otherwise anything 4 bits allow
    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(5))
            0:       return 4'd0;
            1:       return 4'd1;
            2:       return 4'd15;
            default: return LIMIT_W'($urandom_range(15));
        endcase
    endfunction

    function automatic t_req random_req(int enq_pct, int emerg_pct);
        t_req r;
        int   pick;
        r.func = ($urandom_range(99) < enq_pct) ? FUNC_ENQUEUE : FUNC_GRANT;
        case ($urandom_range(7))
            0:       r.req_id = '0;
            1:       r.req_id = '1;
            default: r.req_id = ID_W'($urandom);
        endcase
        pick = $urandom_range(99);
        if (pick < emerg_pct)
            r.req_class = CLS_EMERG;
        else if (pick < 96)
            r.req_class = ($urandom_range(1) != 0) ? CLS_ARRIVE : CLS_DEPART;
        else
            r.req_class = CLS_UNUSED;
        return r;
    endfunction

    // Stimulus
    initial begin
        t_req r;
        int   j;
        int   n_random;
        int   phase_len;
        int   enq_fill;
        int   enq_empty;
        int   emerg_pct;
        n_random = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                drain();
                write_limits(dir_rows[k].arrive_lim, dir_rows[k].depart_lim);
            end else begin
                for (j = 0; j < dir_rows[k].reps; j++) begin
                    r.func      = dir_rows[k].func;
                    r.req_id    = dir_rows[k].req_id + ID_W'(j);
                    r.req_class = dir_rows[k].req_class;
                    send_req(r, dir_rows[k].typed,
                             t_rsp'{dir_rows[k].status, dir_rows[k].grant_id,
                                    dir_rows[k].grant_class});
                end
            end
        end

        // Random phases: new limits, then a filling half and an emptying half
        while (n_random < RANDOM_ITEMS) begin
            drain();
            write_limits(pick_limit(), pick_limit());
            phase_len = $urandom_range(60, 160);
            enq_fill  = $urandom_range(60, 85);
            enq_empty = $urandom_range(15, 45);
            emerg_pct = $urandom_range(0, 30);
            for (j = 0; j < phase_len; j++) begin
                send_req(random_req((j < phase_len / 2) ? enq_fill : enq_empty, emerg_pct),
                         1'b0, '0);
                n_random++;
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("covered %0d requests under %0d burst-limit settings", n_sent, n_settings);
        $display("grants emergency/arriving/departing %0d/%0d/%0d, idle %0d, dropped %0d",
                 n_granted[CLS_EMERG], n_granted[CLS_ARRIVE], n_granted[CLS_DEPART],
                 n_idle, n_dropped);
        if (err_count == 0)
            $display("priority_weighted_three_queue_arbiter regression: pass");
        else
            $display("priority_weighted_three_queue_arbiter regression: fail");
        $finish;
    end

endmodule

[priority_weighted_three_queue_arbiter.f]
+incdir+hdl
hdl/pwtqa_pkg.sv
hdl/pwtqa_ram.sv
hdl/pwtqa_ctrl.sv
hdl/pwtqa_dp.sv
hdl/priority_weighted_three_queue_arbiter.sv
hdl/pwtqa_chk.sv
bench/tb_top.sv
